// File: rtl/bounding_box_accumulate_transform_core_defines.svh
// assertion helpers shared by the rtl
`ifndef BOUNDING_BOX_ACCUMULATE_TRANSFORM_CORE_DEFINES_SVH
`define BOUNDING_BOX_ACCUMULATE_TRANSFORM_CORE_DEFINES_SVH

// same-cycle implication, held off during reset
`define BBAT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bbat: same-cycle check failed");

// next-cycle implication, held off during reset
`define BBAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bbat: next-cycle check failed");

`endif

// File: rtl/bbat_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbat_pkg;

	// fixed field widths
	localparam int COEF_W  = 16;
	localparam int OUT_W   = 32;
	localparam int ROW_W   = 64;
	localparam int CIDX_W  = 2;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_ROW_X = 2'd0;
	localparam logic [CIDX_W-1:0] REG_ROW_Y = 2'd1;
	localparam logic [CIDX_W-1:0] REG_ROW_Z = 2'd2;

	// identity matrix at reset
	localparam logic [ROW_W-1:0] ROW_X_RESET = 64'h0000_0000_0000_0100;
	localparam logic [ROW_W-1:0] ROW_Y_RESET = 64'h0000_0000_0100_0000;
	localparam logic [ROW_W-1:0] ROW_Z_RESET = 64'h0000_0100_0000_0000;

	// input kind codes
	localparam logic KIND_VERTEX = 1'b0;
	localparam logic KIND_FINISH = 1'b1;

	// result space codes
	localparam logic SPACE_LOCAL = 1'b0;
	localparam logic SPACE_WORLD = 1'b1;

	// transform sequence limits
	localparam logic [2:0] LAST_CORNER = 3'd7;
	localparam logic [1:0] LAST_ROW    = 2'd2;
	localparam logic [1:0] LAST_TERM   = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_RUN   = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic       acc_vertex;
		logic       load_local;
		logic       load_world;
		logic       step_valid;
		logic [2:0] corner;
		logic [1:0] row;
		logic [1:0] term;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic have_point;
		logic pipe_busy;
	} status_t;

endpackage

`default_nettype wire

// File: rtl/bbat_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bbat_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire logic            kind,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output bbat_pkg::cmd_t       cmd,
	input  wire bbat_pkg::status_t status
);
	import bbat_pkg::*;

	state_t     state_q;
	logic       out_valid_q;
	logic [2:0] corner_q;
	logic [1:0] row_q;
	logic [1:0] term_q;
	logic       accept;
	logic       slot_free;
	logic       last_step;

	// output slot is free when empty or being drained this cycle
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && ((kind == KIND_VERTEX) || slot_free);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign last_step = (corner_q == LAST_CORNER) && (row_q == LAST_ROW) &&
		(term_q == LAST_TERM);

	// commands to the datapath
	always_comb begin
		cmd            = '0;
		cmd.acc_vertex = accept && (kind == KIND_VERTEX);
		cmd.load_local = accept && (kind == KIND_FINISH);
		cmd.load_world = (state_q == ST_EMIT) && slot_free;
		cmd.step_valid = (state_q == ST_RUN);
		cmd.corner     = corner_q;
		cmd.row        = row_q;
		cmd.term       = term_q;
	end

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load_local) begin
						state_q <= status.have_point ? ST_RUN : ST_EMIT;
					end
				end
				ST_RUN: begin
					if (last_step) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!status.pipe_busy) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// corner / row / term step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= '0;
			row_q    <= '0;
			term_q   <= '0;
		end else if (cmd.load_local) begin
			corner_q <= '0;
			row_q    <= '0;
			term_q   <= '0;
		end else if (cmd.step_valid) begin
			if (term_q == LAST_TERM) begin
				term_q <= '0;
				if (row_q == LAST_ROW) begin
					row_q    <= '0;
					corner_q <= corner_q + 3'd1;
				end else begin
					row_q <= row_q + 2'd1;
				end
			end else begin
				term_q <= term_q + 2'd1;
			end
		end
	end

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_local || cmd.load_world) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

// File: rtl/bbat_dpath.sv
`timescale 1ns / 1ps
`default_nettype none

module bbat_dpath #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  cfg_we,
	input  wire logic [bbat_pkg::CIDX_W-1:0]           cfg_index,
	input  wire logic [bbat_pkg::ROW_W-1:0]            cfg_data,
	input  wire logic signed [COORD_BITS-1:0]          vertex_x,
	input  wire logic signed [COORD_BITS-1:0]          vertex_y,
	input  wire logic signed [COORD_BITS-1:0]          vertex_z,
	input  wire bbat_pkg::cmd_t                        cmd,
	output bbat_pkg::status_t                          status,
	output logic                                       space,
	output logic                                       box_valid,
	output logic signed [bbat_pkg::OUT_W-1:0]          min_x,
	output logic signed [bbat_pkg::OUT_W-1:0]          min_y,
	output logic signed [bbat_pkg::OUT_W-1:0]          min_z,
	output logic signed [bbat_pkg::OUT_W-1:0]          max_x,
	output logic signed [bbat_pkg::OUT_W-1:0]          max_y,
	output logic signed [bbat_pkg::OUT_W-1:0]          max_z
);
	import bbat_pkg::*;

	localparam int PROD_W = COORD_BITS + COEF_W;
	localparam int ACC_A  = PROD_W + 2;
	localparam int ACC_B  = COEF_W + FRAC_BITS + 2;
	localparam int ACC_C  = OUT_W + FRAC_BITS;
	localparam int ACC_AB = (ACC_A > ACC_B) ? ACC_A : ACC_B;
	localparam int ACC_W  = (ACC_AB > ACC_C) ? ACC_AB : ACC_C;
	localparam int EXT_W  = OUT_W - COORD_BITS;

	// matrix rows
	logic [ROW_W-1:0] row_x_q, row_y_q, row_z_q;

	// local box accumulator
	logic                         have_point_q;
	logic signed [COORD_BITS-1:0] lo_x_q, lo_y_q, lo_z_q;
	logic signed [COORD_BITS-1:0] hi_x_q, hi_y_q, hi_z_q;

	// multiply stage
	logic [ROW_W-1:0]             row_sel;
	logic signed [COEF_W-1:0]     coef_sel;
	logic signed [COORD_BITS-1:0] coord_sel;
	logic signed [PROD_W-1:0]     prod_s1;
	logic signed [COEF_W-1:0]     tr_s1;
	logic                         v_s1, first_s1, last_s1, c0_s1;
	logic [1:0]                   row_s1;

	// accumulate stage
	logic signed [ACC_W-1:0] acc_q, acc_base, acc_next, tr_ext, prod_ext;
	logic                    v_s2, c0_s2;
	logic [1:0]              row_s2;

	// world min/max stage
	logic signed [ACC_W-1:0] world_sh;
	logic signed [OUT_W-1:0] world_w;
	logic signed [OUT_W-1:0] wmin_q [3];
	logic signed [OUT_W-1:0] wmax_q [3];

	// output register
	logic                    space_q, box_valid_q;
	logic signed [OUT_W-1:0] min_x_q, min_y_q, min_z_q, max_x_q, max_y_q, max_z_q;

	assign status.have_point = have_point_q;
	assign status.pipe_busy  = v_s1 || v_s2;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_q <= ROW_X_RESET;
			row_y_q <= ROW_Y_RESET;
			row_z_q <= ROW_Z_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_X: row_x_q <= cfg_data;
				REG_ROW_Y: row_y_q <= cfg_data;
				REG_ROW_Z: row_z_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// running box, cleared once the world result is loaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_point_q <= 1'b0;
			lo_x_q <= '0;
			lo_y_q <= '0;
			lo_z_q <= '0;
			hi_x_q <= '0;
			hi_y_q <= '0;
			hi_z_q <= '0;
		end else if (cmd.load_world) begin
			have_point_q <= 1'b0;
			lo_x_q <= '0;
			lo_y_q <= '0;
			lo_z_q <= '0;
			hi_x_q <= '0;
			hi_y_q <= '0;
			hi_z_q <= '0;
		end else if (cmd.acc_vertex) begin
			have_point_q <= 1'b1;
			if (!have_point_q || (vertex_x < lo_x_q)) lo_x_q <= vertex_x;
			if (!have_point_q || (vertex_y < lo_y_q)) lo_y_q <= vertex_y;
			if (!have_point_q || (vertex_z < lo_z_q)) lo_z_q <= vertex_z;
			if (!have_point_q || (vertex_x > hi_x_q)) hi_x_q <= vertex_x;
			if (!have_point_q || (vertex_y > hi_y_q)) hi_y_q <= vertex_y;
			if (!have_point_q || (vertex_z > hi_z_q)) hi_z_q <= vertex_z;
		end
	end

	// operand select for one coefficient times one corner coordinate
	always_comb begin
		case (cmd.row)
			2'd0:    row_sel = row_x_q;
			2'd1:    row_sel = row_y_q;
			2'd2:    row_sel = row_z_q;
			default: row_sel = '0;
		endcase
		case (cmd.term)
			2'd0: begin
				coef_sel  = row_sel[COEF_W-1:0];
				coord_sel = cmd.corner[0] ? hi_x_q : lo_x_q;
			end
			2'd1: begin
				coef_sel  = row_sel[2*COEF_W-1:COEF_W];
				coord_sel = cmd.corner[1] ? hi_y_q : lo_y_q;
			end
			default: begin
				coef_sel  = row_sel[3*COEF_W-1:2*COEF_W];
				coord_sel = cmd.corner[2] ? hi_z_q : lo_z_q;
			end
		endcase
	end

	// stage 1: multiply
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= cmd.step_valid;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= coef_sel * coord_sel;
		tr_s1    <= row_sel[4*COEF_W-1:3*COEF_W];
		first_s1 <= (cmd.term == 2'd0);
		last_s1  <= (cmd.term == LAST_TERM);
		c0_s1    <= (cmd.corner == 3'd0);
		row_s1   <= cmd.row;
	end

	// stage 2: accumulate, translation seeds the sum
	assign tr_ext   = {{(ACC_W-COEF_W){tr_s1[COEF_W-1]}}, tr_s1} <<< FRAC_BITS;
	assign prod_ext = {{(ACC_W-PROD_W){prod_s1[PROD_W-1]}}, prod_s1};
	assign acc_base = first_s1 ? tr_ext : acc_q;
	assign acc_next = acc_base + prod_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			acc_q <= acc_next;
		end
		c0_s2  <= c0_s1;
		row_s2 <= row_s1;
	end

	// stage 3: floor shift and fold into world min/max
	assign world_sh = acc_q >>> FRAC_BITS;
	assign world_w  = world_sh[OUT_W-1:0];

	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (c0_s2 || (world_w < wmin_q[row_s2])) wmin_q[row_s2] <= world_w;
			if (c0_s2 || (world_w > wmax_q[row_s2])) wmax_q[row_s2] <= world_w;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_local) begin
			space_q     <= SPACE_LOCAL;
			box_valid_q <= have_point_q;
			min_x_q <= {{EXT_W{lo_x_q[COORD_BITS-1]}}, lo_x_q};
			min_y_q <= {{EXT_W{lo_y_q[COORD_BITS-1]}}, lo_y_q};
			min_z_q <= {{EXT_W{lo_z_q[COORD_BITS-1]}}, lo_z_q};
			max_x_q <= {{EXT_W{hi_x_q[COORD_BITS-1]}}, hi_x_q};
			max_y_q <= {{EXT_W{hi_y_q[COORD_BITS-1]}}, hi_y_q};
			max_z_q <= {{EXT_W{hi_z_q[COORD_BITS-1]}}, hi_z_q};
		end else if (cmd.load_world) begin
			space_q     <= SPACE_WORLD;
			box_valid_q <= have_point_q;
			min_x_q <= have_point_q ? wmin_q[0] : '0;
			min_y_q <= have_point_q ? wmin_q[1] : '0;
			min_z_q <= have_point_q ? wmin_q[2] : '0;
			max_x_q <= have_point_q ? wmax_q[0] : '0;
			max_y_q <= have_point_q ? wmax_q[1] : '0;
			max_z_q <= have_point_q ? wmax_q[2] : '0;
		end
	end

	assign space     = space_q;
	assign box_valid = box_valid_q;
	assign min_x     = min_x_q;
	assign min_y     = min_y_q;
	assign min_z     = min_z_q;
	assign max_x     = max_x_q;
	assign max_y     = max_y_q;
	assign max_z     = max_z_q;

endmodule

`default_nettype wire

// File: rtl/bounding_box_accumulate_transform_core.sv
// Bounding box accumulator with affine transform of the finished box.
// Input channel (in_valid/in_ready): kind 0 carries a vertex (vertex_x/y/z,
// signed fixed point), kind 1 finishes the current box. Vertices are taken
// one per cycle while the block is idle and fold into a running min/max box.
// A finish transaction yields two output transactions: the local box
// (space 0, last 0) in the next cycle, then the world box (space 1, last 1),
// the min/max of the eight corners mapped by the 3x4 matrix in cfg rows.
// The world box is built by one shared multiplier stepping over 8 corners,
// 3 rows and 3 terms; the products pass the multiply, accumulate and min/max
// stages and the pipeline drains before the world result is loaded; the
// next input can be taken after that; with an empty box it follows right
// behind the local result with box_valid 0 and zero bounds.
// No input is taken while a finish is being worked on; vertices are still
// taken while a result waits at the output.
// Config (cfg_we/cfg_index/cfg_data) writes a matrix row; write only while
// the block is idle. Index 3 is ignored.
// A stalled receiver (out_ready low) holds the output register; the world
// result waits until the local one is taken.
// Reset clears the box and loads the identity matrix.
`timescale 1ns / 1ps
`default_nettype none

`include "bounding_box_accumulate_transform_core_defines.svh"

module bounding_box_accumulate_transform_core #(
	parameter int COORD_BITS = 16,
	parameter int FRAC_BITS  = 8
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [bbat_pkg::CIDX_W-1:0]        cfg_index,
	input  wire logic [bbat_pkg::ROW_W-1:0]         cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               kind,
	input  wire logic signed [COORD_BITS-1:0]       vertex_x,
	input  wire logic signed [COORD_BITS-1:0]       vertex_y,
	input  wire logic signed [COORD_BITS-1:0]       vertex_z,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    space,
	output logic                                    box_valid,
	output logic signed [bbat_pkg::OUT_W-1:0]       min_x,
	output logic signed [bbat_pkg::OUT_W-1:0]       min_y,
	output logic signed [bbat_pkg::OUT_W-1:0]       min_z,
	output logic signed [bbat_pkg::OUT_W-1:0]       max_x,
	output logic signed [bbat_pkg::OUT_W-1:0]       max_y,
	output logic signed [bbat_pkg::OUT_W-1:0]       max_z,
	output logic                                    last
);
	import bbat_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer and handshake control
	bbat_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	// box, matrix and transform datapath
	bbat_dpath #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vertex_x  (vertex_x),
		.vertex_y  (vertex_y),
		.vertex_z  (vertex_z),
		.cmd       (cmd),
		.status    (status),
		.space     (space),
		.box_valid (box_valid),
		.min_x     (min_x),
		.min_y     (min_y),
		.min_z     (min_z),
		.max_x     (max_x),
		.max_y     (max_y),
		.max_z     (max_z)
	);

	// world result marks the end of the run
	assign last = space;

	// checks
	`BBAT_ASSERT_IMPL(a_finish_slot_free, clk, arst_n, in_valid && in_ready && kind, !out_valid || out_ready)
	`BBAT_ASSERT_NEXT(a_local_after_finish, clk, arst_n, in_valid && in_ready && kind, out_valid && !space)
	`BBAT_ASSERT_IMPL(a_no_input_during_steps, clk, arst_n, cmd.step_valid, !in_ready)

endmodule

`default_nettype wire
